// ===== rtl/core/xor_checked_ascii_frame_validator_top_defines.svh =====
// Assertion macros used by the frame validator port checker.
`ifndef XOR_CHECKED_ASCII_FRAME_VALIDATOR_TOP_DEFINES_SVH
`define XOR_CHECKED_ASCII_FRAME_VALIDATOR_TOP_DEFINES_SVH

// Property checked at every clock edge outside of reset.
`define XCAFV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define XCAFV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/xcafv_pkg.sv =====
package xcafv_pkg;

   // Characters that frame the message and form the checksum marker.
   localparam logic [7:0] CHAR_FRAME_OPEN  = 8'h3C;
   localparam logic [7:0] CHAR_FRAME_CLOSE = 8'h3E;
   localparam logic [7:0] CHAR_COMMA       = 8'h2C;
   localparam logic [7:0] CHAR_UPPER_C     = 8'h43;
   localparam logic [7:0] CHAR_UPPER_S     = 8'h53;
   localparam logic [7:0] CHAR_COLON       = 8'h3A;

   // Shortest legal message: open, three payload bytes, close.
   localparam int MIN_FRAME_BYTES = 5;

   // Status codes reported with each result.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_START = 3'd1,
      STATUS_BAD_END   = 3'd2,
      STATUS_TOO_LONG  = 3'd3,
      STATUS_NO_SUM    = 3'd4,
      STATUS_MISMATCH  = 3'd5
   } status_type;

   // How much of the ",CS:" marker has matched so far.
   typedef enum logic [1:0] {
      MARK_NONE  = 2'd0,
      MARK_COMMA = 2'd1,
      MARK_C     = 2'd2,
      MARK_S     = 2'd3
   } mark_type;

   // One input byte as held in the input register.
   typedef struct packed {
      logic [7:0] msg_byte;
      logic       final_byte;
   } item_type;

   // One status result.
   typedef struct packed {
      status_type status;
      logic [7:0] received_sum;
      logic [7:0] computed_sum;
   } result_type;

   // Decoded hex digit.
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // Decodes an ASCII hex digit, upper or lower case.
   function automatic hex_digit_type hex_decode(input logic [7:0] b);
      hex_digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         d.value = 4'(b - 8'h30);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d.value = 4'(b - 8'h37);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d.value = 4'(b - 8'h57);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

// ===== rtl/core/xcafv_in_stage.sv =====
module xcafv_in_stage
   import xcafv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  item_type req_item,
   input  logic     advance,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // The register takes a new byte when it is empty or its byte moves on.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/core/xcafv_frame_check.sv =====
module xcafv_frame_check
   import xcafv_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 3);

   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic             start_seen_ff, start_seen_in;
   logic [7:0]       running_xor_ff, running_xor_in;
   logic [7:0]       xor_before_comma_ff, xor_before_comma_in;
   mark_type         mark_ff, mark_in;
   logic             marker_found_ff, marker_found_in;
   logic [7:0]       frozen_sum_ff, frozen_sum_in;
   logic [7:0]       hex_value_ff, hex_value_in;
   logic             hex_open_ff, hex_open_in;

   logic          first_byte;
   logic          start_ok;
   logic [7:0]    b;
   hex_digit_type digit;

   assign b          = item.msg_byte;
   assign first_byte = (byte_count_ff == '0);
   assign digit      = hex_decode(b);

   // State update for one byte; a final byte returns everything to reset.
   always_comb begin
      byte_count_in       = byte_count_ff;
      start_seen_in       = start_seen_ff;
      running_xor_in      = running_xor_ff;
      xor_before_comma_in = xor_before_comma_ff;
      mark_in             = mark_ff;
      marker_found_in     = marker_found_ff;
      frozen_sum_in       = frozen_sum_ff;
      hex_value_in        = hex_value_ff;
      hex_open_in         = hex_open_ff;
      if (item.final_byte) begin
         byte_count_in       = '0;
         start_seen_in       = 1'b0;
         running_xor_in      = 8'd0;
         xor_before_comma_in = 8'd0;
         mark_in             = MARK_NONE;
         marker_found_in     = 1'b0;
         frozen_sum_in       = 8'd0;
         hex_value_in        = 8'd0;
         hex_open_in         = 1'b0;
      end else begin
         if (byte_count_ff < CNT_W'(MAX_FRAME_BYTES + 2)) begin
            byte_count_in = byte_count_ff + 1'b1;
         end
         if (first_byte) begin
            start_seen_in = (b == CHAR_FRAME_OPEN);
         end else begin
            running_xor_in = running_xor_ff ^ b;
            if (marker_found_ff) begin
               // Collect hex digits until the first byte that is not one.
               if (hex_open_ff) begin
                  if (digit.valid) begin
                     hex_value_in = {hex_value_ff[3:0], digit.value};
                  end else begin
                     hex_open_in = 1'b0;
                  end
               end
            end else if (mark_ff == MARK_COMMA && b == CHAR_UPPER_C) begin
               mark_in = MARK_C;
            end else if (mark_ff == MARK_C && b == CHAR_UPPER_S) begin
               mark_in = MARK_S;
            end else if (mark_ff == MARK_S && b == CHAR_COLON) begin
               marker_found_in = 1'b1;
               frozen_sum_in   = xor_before_comma_ff;
               hex_value_in    = 8'd0;
               hex_open_in     = 1'b1;
               mark_in         = MARK_NONE;
            end else if (b == CHAR_COMMA) begin
               // A comma always starts a new candidate marker.
               xor_before_comma_in = running_xor_ff;
               mark_in             = MARK_COMMA;
            end else begin
               mark_in = MARK_NONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff       <= '0;
         start_seen_ff       <= 1'b0;
         running_xor_ff      <= 8'd0;
         xor_before_comma_ff <= 8'd0;
         mark_ff             <= MARK_NONE;
         marker_found_ff     <= 1'b0;
         frozen_sum_ff       <= 8'd0;
         hex_value_ff        <= 8'd0;
         hex_open_ff         <= 1'b0;
      end else if (step) begin
         byte_count_ff       <= byte_count_in;
         start_seen_ff       <= start_seen_in;
         running_xor_ff      <= running_xor_in;
         xor_before_comma_ff <= xor_before_comma_in;
         mark_ff             <= mark_in;
         marker_found_ff     <= marker_found_in;
         frozen_sum_ff       <= frozen_sum_in;
         hex_value_ff        <= hex_value_in;
         hex_open_ff         <= hex_open_in;
      end
   end

   // Status of a frame that ends with this byte, checks in priority order.
   assign start_ok = first_byte ? (b == CHAR_FRAME_OPEN) : start_seen_ff;

   always_comb begin
      result.received_sum = 8'd0;
      result.computed_sum = 8'd0;
      if (!start_ok) begin
         result.status = STATUS_BAD_START;
      end else if (byte_count_ff < CNT_W'(MIN_FRAME_BYTES - 1) || b != CHAR_FRAME_CLOSE) begin
         result.status = STATUS_BAD_END;
      end else if (byte_count_ff >= CNT_W'(MAX_FRAME_BYTES + 1)) begin
         result.status = STATUS_TOO_LONG;
      end else if (!marker_found_ff) begin
         result.status = STATUS_NO_SUM;
      end else begin
         result.received_sum = hex_value_ff;
         result.computed_sum = frozen_sum_ff;
         result.status = (hex_value_ff == frozen_sum_ff) ? STATUS_OK : STATUS_MISMATCH;
      end
   end

endmodule

// ===== rtl/core/xcafv_out_stage.sv =====
module xcafv_out_stage
   import xcafv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       busy,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // Busy while a result waits and is not taken in this cycle.
   assign busy = valid_ff && !rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== rtl/core/xor_checked_ascii_frame_validator_top.sv =====
// Frame validator for ASCII messages of the form "<payload>" with an XOR
// checksum given as hex digits after a ",CS:" marker in the payload.
// The req channel takes one message byte per transaction, with
// req_final_byte high on the last byte of a message. Only the last byte
// yields a transaction on the rsp channel: a status code and, for an ok or
// mismatch status, the received and computed checksums (zero otherwise).
// Throughput is one byte per cycle unless a final byte waits on a busy result
// register: the per-byte work is a compare, an XOR and a hex digit shift
// between the input register and the result register. A final byte is held
// in the input register, and its result in the result register, which drives rsp_valid.
// When the receiver stalls, the result register holds its transaction; the
// byte after it in the input register keeps moving if it is not a final
// byte, and a final byte waits there until the result register frees up.
// Reset empties both registers and clears all frame state; the next byte accepted
// is taken as the first byte of a new message. After each final byte the
// frame state returns to its reset value on its own.
module xor_checked_ascii_frame_validator_top
   import xcafv_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_msg_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_received_sum,
   output logic [7:0] rsp_computed_sum
);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   logic       out_busy;
   result_type result;
   result_type rsp_result;

   assign req_item.msg_byte   = req_msg_byte;
   assign req_item.final_byte = req_final_byte;

   // A byte moves on unless it is a final byte facing a result register that is full and not taken.
   assign advance = item_valid && !(item.final_byte && out_busy);

   xcafv_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   xcafv_frame_check #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_frame_check (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .result (result)
   );

   xcafv_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && item.final_byte),
      .result     (result),
      .busy       (out_busy),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_status       = rsp_result.status;
   assign rsp_received_sum = rsp_result.received_sum;
   assign rsp_computed_sum = rsp_result.computed_sum;

endmodule

// ===== rtl/core/xcafv_port_checker.sv =====
`include "xor_checked_ascii_frame_validator_top_defines.svh"

module xcafv_port_checker
   import xcafv_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_received_sum,
   input logic [7:0] rsp_computed_sum
);

   // A stalled result transaction holds its payload.
   `XCAFV_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_received_sum) && $stable(rsp_computed_sum), "rsp payload changed while stalled")

   // Sums are reported only for ok and mismatch.
   `XCAFV_ASSERT(a_sums_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK && rsp_status != STATUS_MISMATCH |-> rsp_received_sum == 8'd0 && rsp_computed_sum == 8'd0, "sums not zero on a failed frame")

   // Ok means the sums agree, mismatch means they differ.
   `XCAFV_ASSERT(a_sum_compare, clock, reset, rsp_valid && (rsp_status == STATUS_OK || rsp_status == STATUS_MISMATCH) |-> (rsp_status == STATUS_OK) == (rsp_received_sum == rsp_computed_sum), "status disagrees with sums")

   // With no result waiting, the input side never stalls.
   `XCAFV_ASSERT(a_ready_free, clock, reset, !rsp_valid |-> req_ready, "req stalled with empty result register")

   // Reset leaves no result behind.
   `XCAFV_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "rsp_valid high after reset")

endmodule

bind xor_checked_ascii_frame_validator_top xcafv_port_checker u_port_checker (.*);
